// ----- design/tsts_pkg.sv -----
package tsts_pkg;

   localparam int TIMED_DEPTH = 8;
   localparam int QUEUE_DEPTH = 8;

   localparam int TIW = (TIMED_DEPTH > 1) ? $clog2(TIMED_DEPTH) : 1;
   localparam int TCW = $clog2(TIMED_DEPTH + 1);
   localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   localparam int OP_W   = 2;
   localparam int ACT_W  = 3;
   localparam int DUR_W  = 16;
   localparam int KIND_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_SCHEDULE = 2'd0,
      OP_QUEUE    = 2'd1,
      OP_PROCESS  = 2'd2
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_FIRE = 2'd0,
      KIND_HEAD = 2'd1,
      KIND_ACK  = 2'd2,
      KIND_IDLE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_SCAN = 2'd2,
      ST_HEAD = 2'd3
   } state_type;

   typedef struct packed {
      logic capture;
      logic insert;
      logic scan_step;
      logic head;
      logic idle;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            tick;
      logic            timed_empty;
      logic            queue_empty;
      logic            fire;
      logic            scan_last;
      logic            emitted;
      logic            out_free;
   } status_type;

endpackage

// ----- design/tsts_if.sv -----
interface tsts_req_if;
   logic                        valid;
   logic                        ready;
   logic [tsts_pkg::OP_W-1:0]   op;
   logic [tsts_pkg::ACT_W-1:0]  action;
   logic [tsts_pkg::DUR_W-1:0]  duration;
   logic                        tick;
   logic                        head_done;

   modport source (output valid, op, action, duration, tick, head_done, input ready);
   modport sink (input valid, op, action, duration, tick, head_done, output ready);
endinterface

interface tsts_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tsts_pkg::KIND_W-1:0] kind;
   logic [tsts_pkg::ACT_W-1:0]  action_out;
   logic                        accepted;
   logic                        last;

   modport source (output valid, kind, action_out, accepted, last, input ready);
   modport sink (input valid, kind, action_out, accepted, last, output ready);
endinterface

// ----- design/timed_and_sequential_task_scheduler_core.sv -----
// Flow: ST_IDLE captures a transaction; ST_EXEC then writes the result of a schedule, queue
// or unknown transaction into the output register. A process pass with tick set and a
// non-empty timed list steps through ST_SCAN, one timed entry per cycle while no fire waits
// on the result channel, then ST_HEAD; otherwise it goes to ST_HEAD; results stream out.
// A new transaction is accepted only in ST_IDLE; steps that emit a result wait on stalls.
// Reset: synchronous, active high; clears the controller, store counts and result valid.
module timed_and_sequential_task_scheduler_core (
   input  logic        clock,
   input  logic        reset,
   tsts_req_if.sink    req_if,
   tsts_rsp_if.source  rsp_if
);

   tsts_pkg::cmd_type    cmd;
   tsts_pkg::status_type status;

   tsts_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tsts_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_op         (req_if.op),
      .req_action     (req_if.action),
      .req_duration   (req_if.duration),
      .req_tick       (req_if.tick),
      .req_head_done  (req_if.head_done),
      .rsp_ready      (rsp_if.ready),
      .rsp_valid      (rsp_if.valid),
      .rsp_kind       (rsp_if.kind),
      .rsp_action_out (rsp_if.action_out),
      .rsp_accepted   (rsp_if.accepted),
      .rsp_last       (rsp_if.last)
   );

endmodule

// ----- design/tsts_controller.sv -----
module tsts_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tsts_pkg::status_type status,
   output tsts_pkg::cmd_type    cmd
);

   tsts_pkg::state_type state_ff;
   tsts_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         tsts_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = tsts_pkg::ST_EXEC;
            end
         end
         tsts_pkg::ST_EXEC: begin
            case (status.op)
               tsts_pkg::OP_SCHEDULE,
               tsts_pkg::OP_QUEUE: begin
                  if (status.out_free) begin
                     cmd.insert = 1'b1;
                     state_in   = tsts_pkg::ST_IDLE;
                  end
               end
               tsts_pkg::OP_PROCESS: begin
                  if (status.tick && !status.timed_empty) begin
                     state_in = tsts_pkg::ST_SCAN;
                  end else begin
                     state_in = tsts_pkg::ST_HEAD;
                  end
               end
               default: begin
                  if (status.out_free) begin
                     cmd.idle = 1'b1;
                     state_in = tsts_pkg::ST_IDLE;
                  end
               end
            endcase
         end
         tsts_pkg::ST_SCAN: begin
            if (!status.fire || status.out_free) begin
               cmd.scan_step = 1'b1;
               if (status.scan_last) begin
                  state_in = tsts_pkg::ST_HEAD;
               end
            end
         end
         tsts_pkg::ST_HEAD: begin
            if (!status.queue_empty) begin
               if (status.out_free) begin
                  cmd.head = 1'b1;
                  state_in = tsts_pkg::ST_IDLE;
               end
            end else if (status.emitted) begin
               state_in = tsts_pkg::ST_IDLE;
            end else if (status.out_free) begin
               cmd.idle = 1'b1;
               state_in = tsts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tsts_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/tsts_datapath.sv -----
module tsts_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  tsts_pkg::cmd_type             cmd,
   output tsts_pkg::status_type          status,
   input  logic [tsts_pkg::OP_W-1:0]     req_op,
   input  logic [tsts_pkg::ACT_W-1:0]    req_action,
   input  logic [tsts_pkg::DUR_W-1:0]    req_duration,
   input  logic                          req_tick,
   input  logic                          req_head_done,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [tsts_pkg::KIND_W-1:0]   rsp_kind,
   output logic [tsts_pkg::ACT_W-1:0]    rsp_action_out,
   output logic                          rsp_accepted,
   output logic                          rsp_last
);

   // captured transaction
   logic [tsts_pkg::OP_W-1:0]  op_ff;
   logic [tsts_pkg::ACT_W-1:0] act_ff;
   logic [tsts_pkg::DUR_W-1:0] dur_ff;
   logic                       tick_ff;
   logic                       done_ff;

   // timed list
   logic [tsts_pkg::ACT_W-1:0] t_act_ff [tsts_pkg::TIMED_DEPTH];
   logic [tsts_pkg::DUR_W-1:0] t_cnt_ff [tsts_pkg::TIMED_DEPTH];
   logic [tsts_pkg::TCW-1:0]   t_used_ff, t_used_in;
   logic [tsts_pkg::TIW-1:0]   rd_ff, rd_in;
   logic [tsts_pkg::TIW-1:0]   wr_ff, wr_in;
   logic                       emitted_ff, emitted_in;
   logic                       t_we;
   logic [tsts_pkg::TIW-1:0]   t_widx;
   logic [tsts_pkg::ACT_W-1:0] t_act_in;
   logic [tsts_pkg::DUR_W-1:0] t_cnt_in;
   logic [tsts_pkg::DUR_W-1:0] cur_cnt;
   logic [tsts_pkg::DUR_W-1:0] dec_cnt;
   logic                       fire;
   logic                       scan_last;
   logic                       t_full;
   logic [tsts_pkg::TIMED_DEPTH-1:0] later_fire_vec;
   logic                       later_fire;

   // sequential queue
   logic [tsts_pkg::ACT_W-1:0] q_act_ff [tsts_pkg::QUEUE_DEPTH];
   logic [tsts_pkg::QIW-1:0]   q_head_ff, q_head_in;
   logic [tsts_pkg::QIW-1:0]   q_tail_ff, q_tail_in;
   logic [tsts_pkg::QCW-1:0]   q_used_ff, q_used_in;
   logic                       q_we;
   logic                       q_pop;
   logic                       q_full;

   // output register
   logic                       out_valid_ff, out_valid_in;
   logic [tsts_pkg::KIND_W-1:0] out_kind_ff, out_kind_in;
   logic [tsts_pkg::ACT_W-1:0] out_act_ff, out_act_in;
   logic                       out_acc_ff, out_acc_in;
   logic                       out_last_ff, out_last_in;
   logic                       emit;
   logic                       out_free;

   assign t_full    = (t_used_ff == tsts_pkg::TCW'(tsts_pkg::TIMED_DEPTH));
   assign q_full    = (q_used_ff == tsts_pkg::QCW'(tsts_pkg::QUEUE_DEPTH));
   assign cur_cnt   = t_cnt_ff[rd_ff];
   assign dec_cnt   = (cur_cnt == '0) ? '0 : cur_cnt - tsts_pkg::DUR_W'(1);
   assign fire      = (dec_cnt == '0);
   assign scan_last = ((tsts_pkg::TCW'(rd_ff) + tsts_pkg::TCW'(1)) == t_used_ff);
   assign out_free  = !out_valid_ff || rsp_ready;
   assign emit      = cmd.insert || (cmd.scan_step && fire) || cmd.head || cmd.idle;

   // entries above the read pointer are untouched during the scan
   always_comb begin
      for (int i = 0; i < tsts_pkg::TIMED_DEPTH; i++) begin
         later_fire_vec[i] = (tsts_pkg::TCW'(i) > tsts_pkg::TCW'(rd_ff)) &&
                             (tsts_pkg::TCW'(i) < t_used_ff) &&
                             (t_cnt_ff[i] <= tsts_pkg::DUR_W'(1));
      end
   end
   assign later_fire = |later_fire_vec;

   assign q_we  = cmd.insert && (op_ff == tsts_pkg::OP_QUEUE) && !q_full;
   assign q_pop = cmd.head && done_ff;

   always_comb begin
      status.op          = op_ff;
      status.tick        = tick_ff;
      status.timed_empty = (t_used_ff == '0);
      status.queue_empty = (q_used_ff == '0);
      status.fire        = fire;
      status.scan_last   = scan_last;
      status.emitted     = emitted_ff;
      status.out_free    = out_free;
   end

   always_comb begin
      t_we       = 1'b0;
      t_widx     = wr_ff;
      t_act_in   = t_act_ff[rd_ff];
      t_cnt_in   = dec_cnt;
      t_used_in  = t_used_ff;
      rd_in      = rd_ff;
      wr_in      = wr_ff;
      emitted_in = emitted_ff;
      if (cmd.capture) begin
         rd_in      = '0;
         wr_in      = '0;
         emitted_in = 1'b0;
      end
      if (cmd.insert && (op_ff == tsts_pkg::OP_SCHEDULE) && !t_full) begin
         t_we      = 1'b1;
         t_widx    = t_used_ff[tsts_pkg::TIW-1:0];
         t_act_in  = act_ff;
         t_cnt_in  = (dur_ff == '0) ? tsts_pkg::DUR_W'(1) : dur_ff;
         t_used_in = t_used_ff + tsts_pkg::TCW'(1);
      end
      if (cmd.scan_step) begin
         if (fire) begin
            emitted_in = 1'b1;
         end else begin
            t_we  = 1'b1;
            wr_in = wr_ff + tsts_pkg::TIW'(1);
         end
         if (scan_last) begin
            rd_in     = '0;
            t_used_in = tsts_pkg::TCW'(wr_ff) + tsts_pkg::TCW'(!fire);
         end else begin
            rd_in = rd_ff + tsts_pkg::TIW'(1);
         end
      end
   end

   always_comb begin
      q_tail_in = q_tail_ff;
      q_head_in = q_head_ff;
      q_used_in = q_used_ff;
      if (q_we) begin
         q_tail_in = (q_tail_ff == tsts_pkg::QIW'(tsts_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : q_tail_ff + tsts_pkg::QIW'(1);
         q_used_in = q_used_ff + tsts_pkg::QCW'(1);
      end
      if (q_pop) begin
         q_head_in = (q_head_ff == tsts_pkg::QIW'(tsts_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : q_head_ff + tsts_pkg::QIW'(1);
         q_used_in = q_used_ff - tsts_pkg::QCW'(1);
      end
   end

   always_comb begin
      out_kind_in = out_kind_ff;
      out_act_in  = out_act_ff;
      out_acc_in  = out_acc_ff;
      out_last_in = out_last_ff;
      if (cmd.insert) begin
         out_kind_in = tsts_pkg::KIND_ACK;
         out_act_in  = act_ff;
         out_acc_in  = (op_ff == tsts_pkg::OP_SCHEDULE) ? !t_full : !q_full;
         out_last_in = 1'b1;
      end else if (cmd.scan_step && fire) begin
         out_kind_in = tsts_pkg::KIND_FIRE;
         out_act_in  = t_act_ff[rd_ff];
         out_acc_in  = 1'b0;
         out_last_in = !later_fire && (q_used_ff == '0);
      end else if (cmd.head) begin
         out_kind_in = tsts_pkg::KIND_HEAD;
         out_act_in  = q_act_ff[q_head_ff];
         out_acc_in  = 1'b0;
         out_last_in = 1'b1;
      end else if (cmd.idle) begin
         out_kind_in = tsts_pkg::KIND_IDLE;
         out_act_in  = '0;
         out_acc_in  = 1'b0;
         out_last_in = 1'b1;
      end
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_used_ff    <= '0;
         rd_ff        <= '0;
         wr_ff        <= '0;
         emitted_ff   <= 1'b0;
         q_head_ff    <= '0;
         q_tail_ff    <= '0;
         q_used_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         t_used_ff    <= t_used_in;
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         emitted_ff   <= emitted_in;
         q_head_ff    <= q_head_in;
         q_tail_ff    <= q_tail_in;
         q_used_ff    <= q_used_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_op;
         act_ff  <= req_action;
         dur_ff  <= req_duration;
         tick_ff <= req_tick;
         done_ff <= req_head_done;
      end
      if (t_we) begin
         t_act_ff[t_widx] <= t_act_in;
         t_cnt_ff[t_widx] <= t_cnt_in;
      end
      if (q_we) begin
         q_act_ff[q_tail_ff] <= act_ff;
      end
      out_kind_ff <= out_kind_in;
      out_act_ff  <= out_act_in;
      out_acc_ff  <= out_acc_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_kind_ff;
   assign rsp_action_out = out_act_ff;
   assign rsp_accepted   = out_acc_ff;
   assign rsp_last       = out_last_ff;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (emit && out_valid_ff) |-> rsp_ready)
      else $error("result overwrites an untaken transaction");

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (t_used_ff <= tsts_pkg::TCW'(tsts_pkg::TIMED_DEPTH)) &&
      (q_used_ff <= tsts_pkg::QCW'(tsts_pkg::QUEUE_DEPTH)))
      else $error("store count beyond depth");

   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> (wr_ff <= rd_ff) && (tsts_pkg::TCW'(rd_ff) < t_used_ff))
      else $error("compaction pointers out of order");

   a_head_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.head |-> (q_used_ff != '0))
      else $error("head issued on empty queue");

   a_sched_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.insert && (op_ff == tsts_pkg::OP_SCHEDULE) && !t_full) |=>
      (t_used_ff == $past(t_used_ff) + tsts_pkg::TCW'(1)))
      else $error("timed insert did not grow the list");
`endif

endmodule

// ----- verif/timed_and_sequential_task_scheduler_core_tb.sv -----
`timescale 1ns / 1ps

module timed_and_sequential_task_scheduler_core_tb;
   import tsts_pkg::*;

   localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 140;
   localparam int DRAIN_CYCLES = 24;
   localparam int MAX_WAIT     = 16;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [ACT_W-1:0] action;
      logic [DUR_W-1:0] duration;
      logic             tick;
      logic             head_done;
   } req_type;

   typedef struct packed {
      kind_type         kind;
      logic [ACT_W-1:0] action;
      logic             accepted;
      logic             last;
   } rsp_type;

   // fixed = 1: rsp holds the single known result of this transaction
   typedef struct packed {
      req_type req;
      logic    fixed;
      rsp_type rsp;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tsts_req_if req_if ();
   tsts_rsp_if rsp_if ();

   timed_and_sequential_task_scheduler_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // scheduler state as predicted
   logic [ACT_W-1:0] timer_act  [TIMED_DEPTH];
   logic [DUR_W-1:0] timer_left [TIMED_DEPTH];
   int               timer_cnt = 0;
   logic [ACT_W-1:0] fifo_act   [QUEUE_DEPTH];
   int               fifo_cnt = 0;

   rsp_type pending_rsp [$];
   rsp_type step_rsp    [$];
   row_type fixed_rsp_q [$];
   row_type directed_rows [$];

   int   mismatch_count = 0;
   int   cycles = 0;
   int   sent_random = 0;
   int   long_left = 3;
   logic rush = 1'b0;

   req_type seen_req;
   row_type seen_note;
   rsp_type want;

   function automatic row_type mk_row(input logic [OP_W-1:0] op, input logic [ACT_W-1:0] act,
         input logic [DUR_W-1:0] dur, input logic tick, input logic done,
         input logic fixed = 1'b0, input kind_type kind = KIND_IDLE,
         input logic [ACT_W-1:0] act_o = '0, input logic acc = 1'b0);
      row_type row;
      row.req.op        = op;
      row.req.action    = act;
      row.req.duration  = dur;
      row.req.tick      = tick;
      row.req.head_done = done;
      row.fixed         = fixed;
      row.rsp.kind      = kind;
      row.rsp.action    = act_o;
      row.rsp.accepted  = acc;
      row.rsp.last      = 1'b1;
      return row;
   endfunction

   task automatic add_rsp(input kind_type kind, input logic [ACT_W-1:0] act, input logic acc);
      rsp_type o;
      o.kind     = kind;
      o.action   = act;
      o.accepted = acc;
      o.last     = 1'b0;
      step_rsp.push_back(o);
   endtask

   // Applies one transaction to the predicted state, leaving its results in step_rsp.
   task automatic scheduler_step(input req_type r);
      int               keep;
      logic [DUR_W-1:0] left;
      rsp_type          o;
      step_rsp.delete();
      case (r.op)
         OP_SCHEDULE: begin
            if (timer_cnt < TIMED_DEPTH) begin
               timer_act[timer_cnt]  = r.action;
               timer_left[timer_cnt] = (r.duration == '0) ? DUR_W'(1) : r.duration;
               timer_cnt++;
               add_rsp(KIND_ACK, r.action, 1'b1);
            end else begin
               add_rsp(KIND_ACK, r.action, 1'b0);
            end
         end
         OP_QUEUE: begin
            if (fifo_cnt < QUEUE_DEPTH) begin
               fifo_act[fifo_cnt] = r.action;
               fifo_cnt++;
               add_rsp(KIND_ACK, r.action, 1'b1);
            end else begin
               add_rsp(KIND_ACK, r.action, 1'b0);
            end
         end
         OP_PROCESS: begin
            if (r.tick) begin
               keep = 0;
               for (int i = 0; i < timer_cnt; i++) begin
                  left = (timer_left[i] == '0) ? '0 : timer_left[i] - 1'b1;
                  if (left == '0) begin
                     add_rsp(KIND_FIRE, timer_act[i], 1'b0);
                  end else begin
                     timer_act[keep]  = timer_act[i];
                     timer_left[keep] = left;
                     keep++;
                  end
               end
               timer_cnt = keep;
            end
            if (fifo_cnt > 0) begin
               add_rsp(KIND_HEAD, fifo_act[0], 1'b0);
               if (r.head_done) begin
                  for (int i = 1; i < fifo_cnt; i++)
                     fifo_act[i-1] = fifo_act[i];
                  fifo_cnt--;
               end
            end
            if (step_rsp.size() == 0)
               add_rsp(KIND_IDLE, '0, 1'b0);
         end
         default: begin
            add_rsp(KIND_IDLE, '0, 1'b0);
         end
      endcase
      o = step_rsp.pop_back();
      o.last = 1'b1;
      step_rsp.push_back(o);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, pending_rsp.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result check first, then prediction for a transaction accepted at this edge
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, actual kind=%0d action=%0d %s%0d %s%0d",
                     $time, rsp_if.kind, rsp_if.action_out,
                     "accepted=", rsp_if.accepted, "last=", rsp_if.last);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_if.kind !== want.kind || rsp_if.action_out !== want.action ||
                rsp_if.accepted !== want.accepted || rsp_if.last !== want.last) begin
               mismatch_count++;
               $display("%0t: expected kind=%0d action=%0d accepted=%0d last=%0d, %s%0d %s%0d",
                        $time, want.kind, want.action, want.accepted, want.last,
                        "actual kind=", rsp_if.kind, "action=", rsp_if.action_out);
               $display("%0t: actual accepted=%0d last=%0d",
                        $time, rsp_if.accepted, rsp_if.last);
            end
         end
      end
      if (!reset && req_if.valid && req_if.ready) begin
         seen_req.op        = req_if.op;
         seen_req.action    = req_if.action;
         seen_req.duration  = req_if.duration;
         seen_req.tick      = req_if.tick;
         seen_req.head_done = req_if.head_done;
         scheduler_step(seen_req);
         seen_note = fixed_rsp_q.pop_front();
         if (seen_note.fixed)
            pending_rsp.push_back(seen_note.rsp);
         else
            foreach (step_rsp[i]) pending_rsp.push_back(step_rsp[i]);
      end
   end

   function automatic int draw_wait();
      return rush ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // long durations only late in the run, so they cannot clog the timer list early
   function automatic logic [DUR_W-1:0] pick_duration();
      if (long_left > 0 && sent_random > RANDOM_ITEMS / 2 && $urandom_range(0, 11) == 0) begin
         long_left--;
         return DUR_W'($urandom_range(0, 65535));
      end
      return DUR_W'($urandom_range(0, 4));
   endfunction

   function automatic row_type rand_row(input logic [OP_W-1:0] op);
      return mk_row(op, ACT_W'($urandom_range(0, 7)), pick_duration(),
                    $urandom_range(0, 3) != 0, $urandom_range(0, 4) < 3);
   endfunction

   task automatic send_item(input row_type row);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      fixed_rsp_q.push_back(row);
      req_if.valid     <= 1'b1;
      req_if.op        <= row.req.op;
      req_if.action    <= row.req.action;
      req_if.duration  <= row.req.duration;
      req_if.tick      <= row.req.tick;
      req_if.head_done <= row.req.head_done;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic send_random(input row_type row);
      send_item(row);
      sent_random++;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_rsp.size() != 0 || fixed_rsp_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   initial begin
      logic [DUR_W-1:0] sched_dur [8];
      int               n_sched;
      int               n_queue;
      int               n_pass;
      sched_dur = '{16'd0, 16'd1, 16'd2, 16'hFFFF, 16'd1, 16'd3, 16'd2, 16'd1};

      req_if.valid     <= 1'b0;
      req_if.op        <= OP_SCHEDULE;
      req_if.action    <= '0;
      req_if.duration  <= '0;
      req_if.tick      <= 1'b0;
      req_if.head_done <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty stores, unknown opcode, fill to full, then passes with shifted fires
      directed_rows.push_back(mk_row(OP_PROCESS, 3'd0, 16'd0, 1'b0, 1'b1,
                                     1'b1, KIND_IDLE, 3'd0, 1'b0));
      directed_rows.push_back(mk_row(OP_PROCESS, 3'd7, 16'hFFFF, 1'b1, 1'b1,
                                     1'b1, KIND_IDLE, 3'd0, 1'b0));
      directed_rows.push_back(mk_row(OP_UNKNOWN, 3'd7, 16'hFFFF, 1'b1, 1'b1,
                                     1'b1, KIND_IDLE, 3'd0, 1'b0));
      for (int i = 0; i < TIMED_DEPTH; i++)
         directed_rows.push_back(mk_row(OP_SCHEDULE, ACT_W'(i), sched_dur[i], 1'b0, 1'b0,
                                        1'b1, KIND_ACK, ACT_W'(i), 1'b1));
      directed_rows.push_back(mk_row(OP_SCHEDULE, 3'd5, 16'd7, 1'b1, 1'b1,
                                     1'b1, KIND_ACK, 3'd5, 1'b0));
      for (int i = 0; i < QUEUE_DEPTH; i++)
         directed_rows.push_back(mk_row(OP_QUEUE, ACT_W'(7 - i), 16'hFFFF, 1'b1, 1'b1,
                                        1'b1, KIND_ACK, ACT_W'(7 - i), 1'b1));
      directed_rows.push_back(mk_row(OP_QUEUE, 3'd2, 16'd0, 1'b0, 1'b0,
                                     1'b1, KIND_ACK, 3'd2, 1'b0));
      directed_rows.push_back(mk_row(OP_PROCESS, 3'd0, 16'd0, 1'b1, 1'b0));
      directed_rows.push_back(mk_row(OP_PROCESS, 3'd0, 16'd0, 1'b1, 1'b1));
      directed_rows.push_back(mk_row(OP_PROCESS, 3'd0, 16'd0, 1'b0, 1'b1));
      directed_rows.push_back(mk_row(OP_PROCESS, 3'd0, 16'd0, 1'b1, 1'b0));

      foreach (directed_rows[i]) send_item(directed_rows[i]);
      wait_drained();

      while (sent_random < RANDOM_ITEMS) begin
         case ($urandom_range(0, 6))
            0, 1, 2: begin
               n_sched = $urandom_range(1, TIMED_DEPTH + 1);
               n_queue = $urandom_range(0, QUEUE_DEPTH + 1);
               n_pass  = $urandom_range(2, 8);
               for (int i = 0; i < n_sched; i++) send_random(rand_row(OP_SCHEDULE));
               for (int i = 0; i < n_queue; i++) send_random(rand_row(OP_QUEUE));
               for (int i = 0; i < n_pass; i++) send_random(rand_row(OP_PROCESS));
            end
            3: begin
               n_pass = $urandom_range(1, 6);
               for (int i = 0; i < n_pass; i++) send_random(rand_row(OP_PROCESS));
            end
            4, 5: begin
               n_pass = $urandom_range(1, 4);
               for (int i = 0; i < n_pass; i++) begin
                  send_random(mk_row(OP_W'($urandom_range(0, 3)), ACT_W'($urandom_range(0, 7)),
                                     DUR_W'($urandom_range(0, 65535)) & 16'h0007,
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
               end
            end
            default: begin
               wait_drained();
               rush = ($urandom_range(0, 2) == 0);
            end
         endcase
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
